### rtl/rv64md_pkg.sv
// rv64md_pkg: shared constants for the multiply/divide unit
// no dependencies
`default_nettype none
package rv64md_pkg;
  localparam int unsigned XLEN = 64;
  localparam logic [2:0] OP_MUL    = 3'd0;
  localparam logic [2:0] OP_MULH   = 3'd1;
  localparam logic [2:0] OP_MULHSU = 3'd2;
  localparam logic [2:0] OP_MULHU  = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_DIVU   = 3'd5;
  localparam logic [2:0] OP_REM    = 3'd6;
  localparam logic [2:0] OP_REMU   = 3'd7;
  localparam logic [XLEN-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
endpackage
`default_nettype wire

### rtl/rv64md_div_stage.sv
// rv64md_div_stage: Steps (default 4) combinational restoring-division steps between two registers
// no dependencies
`default_nettype none
module rv64md_div_stage #(
  parameter int unsigned Steps = 4
) (
  input  wire logic [63:0] rem_i,
  input  wire logic [63:0] quo_i,
  input  wire logic [63:0] dvd_i,
  input  wire logic [63:0] dvs_i,
  output logic [63:0] rem_o,
  output logic [63:0] quo_o,
  output logic [63:0] dvd_o
);
  always_comb begin
    logic [64:0] trial;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] d;
    r = rem_i;
    q = quo_i;
    d = dvd_i;
    for (int i = 0; i < Steps; i++) begin
      trial = {r, d[63]} - {1'b0, dvs_i};
      if (!trial[64]) begin
        r = trial[63:0];
        q = {q[62:0], 1'b1};
      end else begin
        r = {r[62:0], d[63]};
        q = {q[62:0], 1'b0};
      end
      d = {d[62:0], 1'b0};
    end
    rem_o = r;
    quo_o = q;
    dvd_o = d;
  end
endmodule
`default_nettype wire

### rtl/rv64m_multiply_divide_unit_core.sv
// rv64m_multiply_divide_unit_core: pipelined RV64M multiply and divide
// depends on rv64md_pkg and rv64md_div_stage
//
//  channel | signals                                  | dir
//  in      | in_valid_i in_ready_o mode_i operand_a_i operand_b_i | in
//  out     | out_valid_o out_ready_i result_o         | out
//
// every word passes the stage 0 register, the divider chain registers and the
// output register; a new word may enter every cycle while the output is not stalled.
// the divider chain resolves the 64 quotient bits 4 per stage. the multiplier is four 32x32 partial products in the
// first stage, summed in the second.
// reset clears only the valid bits. a stall at the output freezes the whole
// chain (in_ready_o = out_ready_i or output register empty), so nothing is
// lost or repeated.
`default_nettype none
module rv64m_multiply_divide_unit_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_o
);
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NStg = 64 / StepsPerStage;

  // global enable: pipeline advances when output is free or taken
  logic adv;
  assign adv = out_ready_i || !out_valid_o;
  assign in_ready_o = adv;

  // stage 0: operand prep and partial products
  logic        v0_q;
  logic [2:0]  m0_q;
  logic [63:0] a0_q, b0_q, ma0_q, mb0_q;
  logic        na0_q, nb0_q, bz0_q;
  logic [63:0] pll_q, plh_q, phl_q, phh_q;

  logic sgn;
  logic na, nb;
  assign sgn = (mode_i == rv64md_pkg::OP_DIV) || (mode_i == rv64md_pkg::OP_REM);
  assign na  = sgn && operand_a_i[63];
  assign nb  = sgn && operand_b_i[63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q  <= mode_i;
      a0_q  <= operand_a_i;
      b0_q  <= operand_b_i;
      ma0_q <= na ? (64'd0 - operand_a_i) : operand_a_i;
      mb0_q <= nb ? (64'd0 - operand_b_i) : operand_b_i;
      na0_q <= na;
      nb0_q <= nb;
      bz0_q <= (operand_b_i == 64'd0);
      pll_q <= operand_a_i[31:0]  * operand_b_i[31:0];
      plh_q <= operand_a_i[31:0]  * operand_b_i[63:32];
      phl_q <= operand_a_i[63:32] * operand_b_i[31:0];
      phh_q <= operand_a_i[63:32] * operand_b_i[63:32];
    end
  end

  // stage 1: product sums, carried along the divider chain
  logic [63:0] mid, lo_prod, hi_prod;
  logic [63:0] hi_fix;
  always_comb begin
    mid     = {32'd0, pll_q[63:32]} + {32'd0, plh_q[31:0]} + {32'd0, phl_q[31:0]};
    lo_prod = {mid[31:0], pll_q[31:0]};
    hi_prod = phh_q + {32'd0, plh_q[63:32]} + {32'd0, phl_q[63:32]}
            + {32'd0, mid[63:32]};
    hi_fix  = 64'd0;
    if ((m0_q == rv64md_pkg::OP_MULH || m0_q == rv64md_pkg::OP_MULHSU) && a0_q[63])
      hi_fix = hi_fix + b0_q;
    if (m0_q == rv64md_pkg::OP_MULH && b0_q[63])
      hi_fix = hi_fix + a0_q;
  end

  // divider chain registers, index 0 is the entry of the chain
  logic [NStg:0]       dv_q;
  logic [63:0]         dr_q  [NStg+1];
  logic [63:0]         dq_q  [NStg+1];
  logic [63:0]         dd_q  [NStg+1];
  logic [63:0]         ds_q  [NStg+1];
  logic [63:0]         ps_q  [NStg+1];  // direct result for mul/special cases
  logic [2:0]          dm_q  [NStg+1];
  logic [NStg:0]       sq_q, sr_q, byp_q;

  // combinational outputs of each divider stage
  logic [63:0]         rn_w  [NStg];
  logic [63:0]         qn_w  [NStg];
  logic [63:0]         dn_w  [NStg];

  logic [63:0] mul_res;
  logic        byp;
  logic [63:0] byp_val;
  always_comb begin
    mul_res = (m0_q == rv64md_pkg::OP_MUL) ? lo_prod : (hi_prod - hi_fix);
    byp     = !m0_q[2] || bz0_q;
    if (!m0_q[2])          byp_val = mul_res;
    else if (!m0_q[1])     byp_val = rv64md_pkg::ALL_ONES;
    else                   byp_val = a0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (adv) begin
      dv_q <= {dv_q[NStg-1:0], v0_q};
    end
  end

  for (genvar g = 0; g < NStg; g++) begin : g_div
    rv64md_div_stage #(.Steps(StepsPerStage)) u_stage (
      .rem_i (dr_q[g]),
      .quo_i (dq_q[g]),
      .dvd_i (dd_q[g]),
      .dvs_i (ds_q[g]),
      .rem_o (rn_w[g]),
      .quo_o (qn_w[g]),
      .dvd_o (dn_w[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q[0]  <= 64'd0;
      dq_q[0]  <= 64'd0;
      dd_q[0]  <= ma0_q;
      ds_q[0]  <= mb0_q;
      ps_q[0]  <= byp_val;
      dm_q[0]  <= m0_q;
      sq_q[0]  <= na0_q ^ nb0_q;
      sr_q[0]  <= na0_q;
      byp_q[0] <= byp;
      for (int i = 0; i < NStg; i++) begin
        dr_q[i+1]  <= rn_w[i];
        dq_q[i+1]  <= qn_w[i];
        dd_q[i+1]  <= dn_w[i];
        ds_q[i+1]  <= ds_q[i];
        ps_q[i+1]  <= ps_q[i];
        dm_q[i+1]  <= dm_q[i];
        sq_q[i+1]  <= sq_q[i];
        sr_q[i+1]  <= sr_q[i];
        byp_q[i+1] <= byp_q[i];
      end
    end
  end

  // final stage: sign fixup and select; overflow case falls out naturally
  logic [63:0] qf, rf, res_d;
  always_comb begin
    qf = sq_q[NStg] ? (64'd0 - dq_q[NStg]) : dq_q[NStg];
    rf = sr_q[NStg] ? (64'd0 - dr_q[NStg]) : dr_q[NStg];
    if (byp_q[NStg])       res_d = ps_q[NStg];
    else if (dm_q[NStg][1]) res_d = rf;
    else                   res_d = qf;
  end

  logic        vo_q;
  logic [63:0] res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= dv_q[NStg];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vo_q;
  assign result_o    = res_q;
endmodule
`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking bench for rv64m_multiply_divide_unit_core
// depends on rv64md_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;

  // scoreboard: predicts each accepted word and checks results in order
  class muldiv_board;
    logic [63:0] pending_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // high half of unsigned 128-bit product
    function automatic logic [63:0] prod_high(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
    endfunction

    function automatic logic [63:0] compute(logic [2:0] op, logic [63:0] a, logic [63:0] b);
      logic [63:0] r, ma, mb, q;
      logic        na, nb;
      na = a[63];
      nb = b[63];
      ma = na ? -a : a;
      mb = nb ? -b : b;
      case (op)
        rv64md_pkg::OP_MUL:    r = a * b;
        rv64md_pkg::OP_MULH:   begin
          r = prod_high(a, b);
          if (na) r = r - b;
          if (nb) r = r - a;
        end
        rv64md_pkg::OP_MULHSU: begin
          r = prod_high(a, b);
          if (na) r = r - b;
        end
        rv64md_pkg::OP_MULHU:  r = prod_high(a, b);
        rv64md_pkg::OP_DIV:    begin
          if (b == 0) r = rv64md_pkg::ALL_ONES;
          else begin
            q = ma / mb;
            r = (na != nb) ? -q : q;
          end
        end
        rv64md_pkg::OP_DIVU:   r = (b == 0) ? rv64md_pkg::ALL_ONES : a / b;
        rv64md_pkg::OP_REM:    begin
          if (b == 0) r = a;
          else begin
            q = ma % mb;
            r = na ? -q : q;
          end
        end
        default:   r = (b == 0) ? a : a % b;
      endcase
      return r;
    endfunction

    function void note_word(logic [2:0] op, logic [63:0] a, logic [63:0] b);
      pending_q.push_back(compute(op, a, b));
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = rv64md_pkg::OP_MUL;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_o;

  muldiv_board board = new();
  int          send_idle_pct = 0;   // sender gap odds, percent
  int          recv_stall_pct = 0;  // receiver stall odds, percent
  bit          hold_off = 1'b0;     // long receiver hold-off request
  longint      cycle_cnt = 0;

  always #1 clk_i = ~clk_i;

  rv64m_multiply_divide_unit_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .operand_a_i,
    .operand_b_i, .out_valid_o, .out_ready_i, .result_o
  );

  // global watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(result_o);
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // operand with bias toward corner values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return rv64md_pkg::ALL_ONES;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'd1;
      5: return {32'd0, $urandom()};
      6: return {{32{1'b1}}, $urandom()};
      7: return 64'($urandom_range(15));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // offer one word, hold it until accepted
  task automatic send_word(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(op, a, b);
  endtask

  task automatic run_random(int count);
    repeat (count) send_word(3'($urandom_range(7)), pick_operand(), pick_operand());
  endtask

  logic [63:0] corner_a[6] = '{64'd0, rv64md_pkg::ALL_ONES, 64'h8000_0000_0000_0000,
                               64'h7FFF_FFFF_FFFF_FFFF, 64'd7, 64'hFFFF_FFFF_FFFF_FFF9};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: every op on extremes, divide by zero and signed overflow
    for (int op = 0; op < 8; op++) begin
      send_word(3'(op), corner_a[op % 6], corner_a[(op + 2) % 6]);
      send_word(3'(op), 64'h8000_0000_0000_0000, rv64md_pkg::ALL_ONES);
      send_word(3'(op), {$urandom(), $urandom()}, 64'd0);
    end
    // no idling
    run_random(400);
    // sender idle 70 of 100
    send_idle_pct = 70;
    run_random(400);
    // receiver stalls 70 of 100
    send_idle_pct = 0;
    recv_stall_pct = 70;
    run_random(400);
    // both
    send_idle_pct = 32;
    recv_stall_pct = 32;
    run_random(400);
    // long hold-off so the pipe fills and backs up the input
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_idle_pct = 0;
        run_random(276);
      end
    join
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### rv64m_multiply_divide_unit_core.f
rtl/rv64md_pkg.sv
rtl/rv64md_div_stage.sv
rtl/rv64m_multiply_divide_unit_core.sv
tb/sv/tb.sv
